### rtl/hti_pkg.sv
// Shared widths, register indexes and the calibration table for the humidity
// table interpolator. No dependencies.
package hti_pkg;

    localparam int CNT_W      = 14;
    localparam int TEMP_W     = 8;
    localparam int GAIN_W     = 8;
    localparam int OFFSET_W   = 18;
    localparam int RH_W       = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;

    localparam logic [GAIN_W-1:0]          GAIN_RST   = 8'd15;
    localparam logic signed [OFFSET_W-1:0] OFFSET_RST = -18'sd42000;

    // Calibration table: 17 rows (5 %RH bands) by 12 temperature columns,
    // entries are counts times ten, stored row-major.
    localparam int CAL_ROWS  = 17;
    localparam int CAL_COLS  = 12;
    localparam int CAL_DEPTH = CAL_ROWS * CAL_COLS;
    localparam int CAL_W     = 20;
    localparam int CAL_AW    = $clog2(CAL_DEPTH);

    localparam logic [CAL_W-1:0] CAL_TAB [0:CAL_DEPTH-1] = '{
        20'd999990, 20'd999990, 20'd999990, 20'd999990, 20'd999990, 20'd999990,
        20'd999990, 20'd999990, 20'd999990, 20'd999990, 20'd999990, 20'd999990,
        20'd200000, 20'd200000, 20'd140000, 20'd90000, 20'd72000, 20'd50000,
        20'd36000, 20'd25000, 20'd18000, 20'd13000, 20'd11000, 20'd11000,
        20'd99000, 20'd99000, 20'd69000, 20'd46000, 20'd32000, 20'd23000,
        20'd17000, 20'd11000, 20'd9200, 20'd6000, 20'd5200, 20'd5200,
        20'd44000, 20'd44000, 20'd31000, 20'd20000, 20'd15000, 20'd9200,
        20'd7700, 20'd5300, 20'd4300, 20'd2800, 20'd2500, 20'd2500,
        20'd19000, 20'd19000, 20'd14000, 20'd9000, 20'd6700, 20'd4500,
        20'd3600, 20'd2500, 20'd2100, 20'd1400, 20'd1140, 20'd1140,
        20'd8100, 20'd8100, 20'd6000, 20'd4300, 20'd3100, 20'd2200,
        20'd1700, 20'd1300, 20'd960, 20'd740, 20'd610, 20'd610,
        20'd4200, 20'd4200, 20'd3000, 20'd2200, 20'd1600, 20'd1200,
        20'd900, 20'd710, 20'd550, 20'd430, 20'd350, 20'd350,
        20'd2110, 20'd2110, 20'd1500, 20'd1100, 20'd830, 20'd660,
        20'd510, 20'd400, 20'd310, 20'd250, 20'd200, 20'd200,
        20'd1090, 20'd1090, 20'd830, 20'd620, 20'd480, 20'd370,
        20'd290, 20'd230, 20'd190, 20'd150, 20'd130, 20'd130,
        20'd630, 20'd630, 20'd480, 20'd370, 20'd290, 20'd230,
        20'd180, 20'd150, 20'd120, 20'd102, 20'd87, 20'd87,
        20'd370, 20'd370, 20'd280, 20'd220, 20'd180, 20'd140,
        20'd120, 20'd100, 20'd81, 20'd69, 20'd59, 20'd59,
        20'd220, 20'd220, 20'd170, 20'd140, 20'd120, 20'd96,
        20'd80, 20'd68, 20'd58, 20'd49, 20'd43, 20'd43,
        20'd140, 20'd140, 20'd120, 20'd94, 20'd78, 20'd65,
        20'd55, 20'd47, 20'd41, 20'd34, 20'd30, 20'd30,
        20'd90, 20'd90, 20'd73, 20'd60, 20'd50, 20'd42,
        20'd38, 20'd33, 20'd29, 20'd24, 20'd20, 20'd20,
        20'd60, 20'd60, 20'd48, 20'd39, 20'd33, 20'd28,
        20'd25, 20'd22, 20'd20, 20'd17, 20'd14, 20'd14,
        20'd40, 20'd40, 20'd32, 20'd27, 20'd22, 20'd19,
        20'd17, 20'd15, 20'd14, 20'd12, 20'd11, 20'd11,
        20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0,
        20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0
    };

    localparam logic [RH_W-1:0] RH_ABOVE_TOP = 7'd15;
    localparam logic [RH_W-1:0] RH_NOT_FOUND = 7'd95;

endpackage

### rtl/hti_in_if.sv
// Input channel of the humidity table interpolator: valid/ready plus one
// reading item. Depends on hti_pkg.
interface hti_in_if import hti_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CNT_W-1:0]         edge_count;
    logic signed [TEMP_W-1:0] temperature;

    modport source (output valid, output edge_count, output temperature, input ready);
    modport sink   (input valid, input edge_count, input temperature, output ready);
endinterface

### rtl/hti_out_if.sv
// Output channel of the humidity table interpolator: valid/ready plus one
// result item. Depends on hti_pkg.
interface hti_out_if import hti_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [RH_W-1:0] humidity;
    logic            out_of_range;

    modport source (output valid, output humidity, output out_of_range, input ready);
    modport sink   (input valid, input humidity, input out_of_range, output ready);
endinterface

### rtl/hti_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module hti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/humidity_table_interpolator.sv
// Humidity table interpolator top level: scaling, row search over the
// calibration RAM, band interpolation and column blend. Depends on hti_pkg,
// hti_in_if, hti_out_if and hti_ram.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-------------------------------------
//   i_in     | in  | valid/ready        | edge_count[13:0], temperature[7:0] s
//   o_out    | out | valid/ready        | humidity[6:0], out_of_range
//   i_cfg_*  | in  | write enable only  | idx 0 gain[7:0], idx 1 offset[17:0] s
//
// After reset the calibration RAM is loaded from the package table, one entry
// a cycle, through the whole table; no item is accepted until the load is done.
// An item's time from acceptance to result is set by the row search, which
// reads one table entry per cycle through the single RAM read port, plus a
// band divide per column when a row is found.
// One item is in work at a time; the result waits in the output register, and
// the next item is taken as soon as that register is loaded.
// A stalled output holds its result; work stops in the final state until the
// output register is free.
module humidity_table_interpolator import hti_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    hti_in_if.sink                i_in,
    hti_out_if.source             o_out
);

    typedef enum logic [10:0] {
        S_FILL   = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_SCALE  = 11'b00000000100,
        S_TIMES  = 11'b00000001000,
        S_ISSUE  = 11'b00000010000,
        S_SEARCH = 11'b00000100000,
        S_NUM    = 11'b00001000000,
        S_DIV    = 11'b00010000000,
        S_COLEND = 11'b00100000000,
        S_BLEND  = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } t_state;

    localparam logic [4:0]        LAST_ROW  = 5'(CAL_ROWS - 1);
    localparam logic [CAL_AW-1:0] LAST_ADDR = CAL_AW'(CAL_DEPTH - 1);

    // Flat address of a table entry: row * 12 + col.
    function automatic logic [CAL_AW-1:0] tab_addr(input logic [4:0] row,
                                                   input logic [3:0] col);
        logic [CAL_AW-1:0] row_w;
        row_w    = CAL_AW'(row);
        tab_addr = (row_w << 3) + (row_w << 2) + CAL_AW'(col);
    endfunction

    t_state r_state, n_state;

    // configuration
    logic [GAIN_W-1:0]          r_gain;
    logic signed [OFFSET_W-1:0] r_offset;

    // RAM load
    logic [CAL_AW-1:0] r_fill, n_fill;

    // item context
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [3:0]         r_left, n_left;
    logic [2:0]         r_frac, n_frac;
    logic signed [23:0] r_scaled, n_scaled;
    logic signed [27:0] r_r, n_r;
    logic               r_col_sel, n_col_sel;
    logic               r_oor, n_oor;

    // row search and band divide
    logic [4:0]       r_row, n_row;
    logic [CAL_W-1:0] r_hi, n_hi;
    logic [CAL_W-1:0] r_den, n_den;
    logic [CAL_W-1:0] r_diff, n_diff;
    logic [22:0]      r_num, n_num;
    logic [2:0]       r_q, n_q;
    logic [1:0]       r_k, n_k;
    logic [RH_W-1:0]  r_col_rh, n_col_rh;
    logic [RH_W-1:0]  r_lrh, n_lrh;
    logic [RH_W-1:0]  r_rrh, n_rrh;
    logic [9:0]       r_sum, n_sum;

    // output register
    logic            r_out_valid, n_out_valid;
    logic [RH_W-1:0] r_out_rh, n_out_rh;
    logic            r_out_oor, n_out_oor;

    // RAM ports
    logic              w_we;
    logic [CAL_AW-1:0] w_raddr;
    logic [CAL_W-1:0]  w_rdata;

    // combinational helpers
    logic [5:0]          w_tclamp;
    logic [9:0]          w_t13;
    logic [3:0]          w_col;
    logic [4:0]          w_row_next;
    logic signed [27:0]  w_tab;
    logic [21:0]         w_prod;
    logic signed [27:0]  w_s28;
    logic [22:0]         w_shifted;
    logic [2:0]          w_q;
    logic [16:0]         w_div5;

    hti_ram #(
        .WIDTH (CAL_W),
        .DEPTH (CAL_DEPTH)
    ) u_cal_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fill),
        .i_wdata (CAL_TAB[r_fill]),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_we        = (r_state == S_FILL);
    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.humidity     = r_out_rh;
    assign o_out.out_of_range = r_out_oor;

    // Clamp temperature to 5..50, then split into column and remainder;
    // t * 13 >> 6 equals t / 5 over that range.
    always_comb begin
        if (i_in.temperature < 8'sd5) begin
            w_tclamp = 6'd5;
        end else if (i_in.temperature > 8'sd50) begin
            w_tclamp = 6'd50;
        end else begin
            w_tclamp = i_in.temperature[5:0];
        end
        w_t13 = (10'(w_tclamp) << 3) + (10'(w_tclamp) << 2) + 10'(w_tclamp);
    end

    assign w_col      = r_left + 4'(r_col_sel);
    assign w_row_next = (r_row == LAST_ROW) ? r_row : r_row + 5'd1;
    assign w_tab      = signed'({8'd0, w_rdata});
    assign w_prod     = 22'(r_gain) * 22'(r_cnt);
    assign w_s28      = {{4{r_scaled[23]}}, r_scaled};
    assign w_shifted  = 23'(r_den) << r_k;
    // sum / 5 as sum * 205 >> 10, exact for sums up to 475
    assign w_div5     = (17'(r_sum) << 7) + (17'(r_sum) << 6) + (17'(r_sum) << 3)
                      + (17'(r_sum) << 2) + 17'(r_sum);

    always_comb begin
        w_q = r_q;
        if (r_num >= w_shifted) begin
            w_q = r_q | (3'd1 << r_k);
        end
    end

    always_comb begin
        unique case (r_state)
            S_ISSUE:  w_raddr = tab_addr(5'd0, w_col);
            S_SEARCH: w_raddr = tab_addr(w_row_next, w_col);
            default:  w_raddr = '0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_frac      = r_frac;
        n_scaled    = r_scaled;
        n_r         = r_r;
        n_col_sel   = r_col_sel;
        n_oor       = r_oor;
        n_row       = r_row;
        n_hi        = r_hi;
        n_den       = r_den;
        n_diff      = r_diff;
        n_num       = r_num;
        n_q         = r_q;
        n_k         = r_k;
        n_col_rh    = r_col_rh;
        n_lrh       = r_lrh;
        n_rrh       = r_rrh;
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        n_out_rh    = r_out_rh;
        n_out_oor   = r_out_oor;

        // drop the result once taken; a new load below overrides
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_FILL: begin
                n_fill = r_fill + CAL_AW'(1);
                if (r_fill == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_cnt     = i_in.edge_count;
                    n_left    = w_t13[9:6];
                    n_frac    = 3'(w_tclamp - ((6'(w_t13[9:6]) << 2) + 6'(w_t13[9:6])));
                    n_oor     = 1'b0;
                    n_col_sel = 1'b0;
                    n_state   = S_SCALE;
                end
            end
            S_SCALE: begin
                n_scaled = signed'({2'b00, w_prod})
                         + {{(24 - OFFSET_W){r_offset[OFFSET_W-1]}}, r_offset};
                n_state  = S_TIMES;
            end
            S_TIMES: begin
                n_r     = (w_s28 <<< 3) + (w_s28 <<< 1);
                n_state = S_ISSUE;
            end
            S_ISSUE: begin
                n_row   = 5'd0;
                n_state = S_SEARCH;
            end
            S_SEARCH: begin
                priority if (r_row == 5'd0 && r_r > w_tab) begin
                    n_col_rh = RH_ABOVE_TOP;
                    n_oor    = 1'b1;
                    n_state  = S_COLEND;
                end else if (r_row != 5'd0 && w_tab < r_r) begin
                    // r lies in (lo, hi]: both differences fit the entry width
                    n_den   = r_hi - w_rdata;
                    n_diff  = r_hi - r_r[CAL_W-1:0];
                    n_state = S_NUM;
                end else if (r_row == LAST_ROW) begin
                    n_col_rh = RH_NOT_FOUND;
                    n_oor    = 1'b1;
                    n_state  = S_COLEND;
                end else begin
                    n_hi  = w_rdata;
                    n_row = w_row_next;
                end
            end
            S_NUM: begin
                n_num   = (23'(r_diff) << 2) + 23'(r_diff);
                n_q     = 3'd0;
                n_k     = 2'd2;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_num >= w_shifted) begin
                    n_num = r_num - w_shifted;
                end
                n_q = w_q;
                n_k = r_k - 2'd1;
                if (r_k == 2'd0) begin
                    n_col_rh = 7'd10 + (7'(r_row) << 2) + 7'(r_row) + 7'(w_q);
                    n_state  = S_COLEND;
                end
            end
            S_COLEND: begin
                if (!r_col_sel) begin
                    n_lrh     = r_col_rh;
                    n_col_sel = 1'b1;
                    n_state   = S_ISSUE;
                end else begin
                    n_rrh   = r_col_rh;
                    n_state = S_BLEND;
                end
            end
            S_BLEND: begin
                n_sum   = 10'(r_lrh) * 10'(3'd5 - r_frac) + 10'(r_rrh) * 10'(r_frac);
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_rh    = w_div5[16:10];
                    n_out_oor   = r_oor;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_gain      <= GAIN_RST;
            r_offset    <= OFFSET_RST;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_GAIN:   r_gain   <= i_cfg_data[GAIN_W-1:0];
                    REG_OFFSET: r_offset <= signed'(i_cfg_data[OFFSET_W-1:0]);
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_left    <= n_left;
        r_frac    <= n_frac;
        r_scaled  <= n_scaled;
        r_r       <= n_r;
        r_col_sel <= n_col_sel;
        r_oor     <= n_oor;
        r_row     <= n_row;
        r_hi      <= n_hi;
        r_den     <= n_den;
        r_diff    <= n_diff;
        r_num     <= n_num;
        r_q       <= n_q;
        r_k       <= n_k;
        r_col_rh  <= n_col_rh;
        r_lrh     <= n_lrh;
        r_rrh     <= n_rrh;
        r_sum     <= n_sum;
        r_out_rh  <= n_out_rh;
        r_out_oor <= n_out_oor;
    end

endmodule

### rtl/hti_checker.sv
// Port-level checks for the humidity table interpolator, attached by bind.
// Depends on hti_pkg and humidity_table_interpolator.
module hti_checker import hti_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input logic [RH_W-1:0] i_humidity,
    input logic            i_out_of_range
);

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    // a waiting result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_humidity) && $stable(i_out_of_range)))
        else $error("result changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("second item taken while one is in work");

    // humidity stays inside the table bands
    a_rh_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_humidity >= RH_ABOVE_TOP && i_humidity <= RH_NOT_FOUND))
        else $error("humidity outside table bands");

    // an out-of-range result carries one of the two bound values
    a_oor_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_of_range) |->
            (i_humidity == RH_ABOVE_TOP || i_humidity == RH_NOT_FOUND))
        else $error("out-of-range flag with interpolated humidity");

endmodule

bind humidity_table_interpolator hti_checker u_hti_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_humidity     (o_out.humidity),
    .i_out_of_range (o_out.out_of_range)
);
